FILE: src/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the streaming MD5 engine.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam int WordWidth  = 32;
  localparam int BlockWords = 16;
  localparam int NumRounds  = 64;

  localparam logic [7:0] PadMark = 8'h80;

  localparam logic [WordWidth-1:0] InitA = 32'h67452301;
  localparam logic [WordWidth-1:0] InitB = 32'hefcdab89;
  localparam logic [WordWidth-1:0] InitC = 32'h98badcfe;
  localparam logic [WordWidth-1:0] InitD = 32'h10325476;

  // Source of the byte written into the block buffer.
  localparam logic [1:0] SelData = 2'd0;
  localparam logic [1:0] SelMark = 2'd1;
  localparam logic [1:0] SelZero = 2'd2;
  localparam logic [1:0] SelLen  = 2'd3;

  typedef struct packed {
    logic       write_en;    // write one byte at the current position
    logic [1:0] byte_sel;    // which byte is written
    logic       load_work;   // copy the chaining words into the work words
    logic       round_en;    // run one round
    logic [5:0] round_idx;   // round number of this cycle
    logic       fold;        // add the work words into the chaining words
    logic       latch_len;   // capture the message bit length
    logic       clear;       // return to the initial values
    logic       out_half;    // digest half shown on the output
  } md5_cmd_t;

  typedef struct packed {
    logic pos_last;          // position is the last byte of a block
    logic pos_len;           // position is the first length byte
  } md5_stat_t;

  function automatic logic [WordWidth-1:0] round_const(input logic [5:0] i);
    logic [WordWidth-1:0] k;
    unique case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Index of the message word used in round i (all arithmetic modulo 16).
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] r;
    logic [3:0] g;
    r = i[3:0];
    unique case (i[5:4])
      2'd0: g = r;
      2'd1: g = r * 4'd5 + 4'd1;
      2'd2: g = r * 4'd3 + 4'd5;
      2'd3: g = r * 4'd7;
      default: g = r;
    endcase
    return g;
  endfunction

endpackage

FILE: src/md5_ctrl.sv
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer of the MD5 engine: byte intake, padding, rounds and digest output.
// ----------------------------------------------------------------------------
module md5_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  logic              has_byte,
  input  logic              is_last,
  output logic              digest_valid,
  input  logic              digest_stall,
  output logic              half_index,
  output logic              final_flag,
  input  md5_pkg::md5_stat_t stat,
  output md5_pkg::md5_cmd_t  cmd
);
  import md5_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StPadMark = 3'd1;
  localparam logic [2:0] StPadZero = 3'd2;
  localparam logic [2:0] StPadLen  = 3'd3;
  localparam logic [2:0] StComp    = 3'd4;
  localparam logic [2:0] StFold    = 3'd5;
  localparam logic [2:0] StOut0    = 3'd6;
  localparam logic [2:0] StOut1    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] ret;
  logic [2:0] ret_next;
  logic [5:0] round;
  logic [5:0] round_next;
  logic       accept;

  assign byte_stall   = (state != StIdle);
  assign accept       = byte_valid && (state == StIdle);
  assign digest_valid = (state == StOut0) || (state == StOut1);
  assign half_index   = (state == StOut1);
  assign final_flag   = (state == StOut1);

  always_comb begin
    state_next    = state;
    ret_next      = ret;
    round_next    = round;
    cmd           = '0;
    cmd.byte_sel  = SelData;
    cmd.round_idx = round;
    cmd.out_half  = (state == StOut1);
    unique case (state)
      StIdle: begin
        if (accept) begin
          cmd.write_en = has_byte;
          if (has_byte && stat.pos_last) begin
            // The byte completes a block: compress before anything else.
            cmd.load_work = 1'b1;
            state_next    = StComp;
            ret_next      = is_last ? StPadMark : StIdle;
          end else if (is_last) begin
            state_next = StPadMark;
          end
        end
      end
      StPadMark: begin
        cmd.write_en  = 1'b1;
        cmd.byte_sel  = SelMark;
        cmd.latch_len = 1'b1;
        if (stat.pos_last) begin
          cmd.load_work = 1'b1;
          state_next    = StComp;
          ret_next      = StPadZero;
        end else begin
          state_next = StPadZero;
        end
      end
      StPadZero: begin
        cmd.write_en = 1'b1;
        if (stat.pos_len) begin
          cmd.byte_sel = SelLen;
          state_next   = StPadLen;
        end else begin
          cmd.byte_sel = SelZero;
          if (stat.pos_last) begin
            cmd.load_work = 1'b1;
            state_next    = StComp;
            ret_next      = StPadZero;
          end
        end
      end
      StPadLen: begin
        cmd.write_en = 1'b1;
        cmd.byte_sel = SelLen;
        if (stat.pos_last) begin
          cmd.load_work = 1'b1;
          state_next    = StComp;
          ret_next      = StOut0;
        end
      end
      StComp: begin
        cmd.round_en = 1'b1;
        round_next   = round + 6'd1;
        if (round == 6'(NumRounds - 1)) begin
          state_next = StFold;
        end
      end
      StFold: begin
        cmd.fold   = 1'b1;
        state_next = ret;
      end
      StOut0: begin
        if (!digest_stall) begin
          state_next = StOut1;
        end
      end
      StOut1: begin
        if (!digest_stall) begin
          cmd.clear  = 1'b1;
          state_next = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      ret   <= StIdle;
      round <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      round <= round_next;
    end
  end

endmodule

FILE: src/md5_dp.sv
// ----------------------------------------------------------------------------
// md5_dp
// Datapath of the MD5 engine: block buffer, byte count, round unit, chaining.
// ----------------------------------------------------------------------------
module md5_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         data_byte,
  input  md5_pkg::md5_cmd_t  cmd,
  output md5_pkg::md5_stat_t stat,
  output logic [63:0]        digest_half
);
  import md5_pkg::*;

  logic [WordWidth-1:0] chain [4];
  logic [WordWidth-1:0] work  [4];
  logic [WordWidth-1:0] block [BlockWords];
  logic [63:0]          msg_count;
  logic [63:0]          bit_len;

  logic [5:0]           pos;
  logic [7:0]           wr_byte;
  logic [WordWidth-1:0] f_val;
  logic [WordWidth-1:0] sum;
  logic [4:0]           rot;
  logic [63:0]          rot_wide;
  logic [WordWidth-1:0] b_next;

  assign pos           = msg_count[5:0];
  assign stat.pos_last = (pos == 6'd63);
  assign stat.pos_len  = (pos == 6'd56);

  assign digest_half = cmd.out_half ? {chain[3], chain[2]} : {chain[1], chain[0]};

  always_comb begin
    unique case (cmd.byte_sel)
      SelData: wr_byte = data_byte;
      SelMark: wr_byte = PadMark;
      SelZero: wr_byte = 8'h00;
      SelLen:  wr_byte = bit_len[{pos[2:0], 3'b000} +: 8];
      default: wr_byte = 8'h00;
    endcase
  end

  // One MD5 round on the work words a, b, c, d.
  always_comb begin
    unique case (cmd.round_idx[5:4])
      2'd0: f_val = (work[1] & work[2]) | (~work[1] & work[3]);
      2'd1: f_val = (work[3] & work[1]) | (~work[3] & work[2]);
      2'd2: f_val = work[1] ^ work[2] ^ work[3];
      2'd3: f_val = work[2] ^ (work[1] | ~work[3]);
      default: f_val = '0;
    endcase
    sum      = work[0] + f_val + round_const(cmd.round_idx)
               + block[msg_index(cmd.round_idx)];
    rot      = rot_amount(cmd.round_idx);
    rot_wide = {sum, sum} << rot;
    b_next   = work[1] + rot_wide[63:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0]  <= InitA;
      chain[1]  <= InitB;
      chain[2]  <= InitC;
      chain[3]  <= InitD;
      msg_count <= '0;
    end else begin
      if (cmd.clear) begin
        chain[0]  <= InitA;
        chain[1]  <= InitB;
        chain[2]  <= InitC;
        chain[3]  <= InitD;
        msg_count <= '0;
      end else begin
        if (cmd.fold) begin
          for (int j = 0; j < 4; j++) begin
            chain[j] <= chain[j] + work[j];
          end
        end
        if (cmd.write_en) begin
          msg_count <= msg_count + 64'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_en) begin
      block[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (cmd.latch_len) begin
      bit_len <= {msg_count[60:0], 3'b000};
    end
    if (cmd.load_work) begin
      for (int j = 0; j < 4; j++) begin
        work[j] <= chain[j];
      end
    end else if (cmd.round_en) begin
      work[0] <= work[3];
      work[1] <= b_next;
      work[2] <= work[1];
      work[3] <= work[2];
    end
  end

endmodule

FILE: src/md5_stream_hash_core.sv
// ----------------------------------------------------------------------------
// md5_stream_hash_core
// Streaming MD5 engine: one message byte per transaction, two-part digest.
// ----------------------------------------------------------------------------
// The engine takes one message byte per input transaction and can accept the
// next transaction at once, except when a byte completes a 64-byte block:
// the shared round unit then runs the 64 rounds, one per cycle, and then adds
// the result into the chaining words, and input stalls until that is done.
// A transaction with is_last set finishes the message: the padding is
// written one byte per cycle, pausing for one or two further compressions,
// and then the digest comes out as two result transactions, digest bytes
// 0-7 first and bytes 8-15 with final_flag set. Input stays stalled until
// both halves have been taken; after that the engine is back at the initial
// values and ready for the next message.
// ----------------------------------------------------------------------------
module md5_stream_hash_core (
  input  logic        clk,
  input  logic        rst,
  // Message byte channel.
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        is_last,
  // Digest channel.
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [63:0] digest_half,
  output logic        half_index,
  output logic        final_flag
);
  import md5_pkg::*;

  md5_cmd_t  cmd;
  md5_stat_t stat;

  // The controller sequences intake, padding, rounds and the output of both
  // digest halves; it holds the round counter.
  md5_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .has_byte     (has_byte),
    .is_last      (is_last),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .half_index   (half_index),
    .final_flag   (final_flag),
    .stat         (stat),
    .cmd          (cmd)
  );

  // The datapath holds the block buffer, the byte count, the work and chaining
  // words, and the single round unit. The digest is read straight from the
  // chaining words, which stay put while a result transaction is stalled.
  md5_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .stat        (stat),
    .digest_half (digest_half)
  );

endmodule
